FILE: hdl/gclp_pkg.sv
`timescale 1ns / 1ps

package gclp_pkg;

  localparam int unsigned MAX_BODY = 59;
  localparam int unsigned BODY_CNT_W = 6;

  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_N     = 8'd78;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_I     = 8'd73;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_LOW_Z = 8'd122;
  localparam logic [7:0] CH_CASE  = 8'd32;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LINE     = 3'd1;
  localparam logic [2:0] ST_ADDR     = 3'd2;
  localparam logic [2:0] ST_LETTER   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  typedef enum logic [3:0] {
    PH_START_N,
    PH_NUM_N,
    PH_START_A,
    PH_NUM_A,
    PH_LETTER,
    PH_CODE,
    PH_PREBODY,
    PH_BODY,
    PH_CHECK,
    PH_DONE
  } gclp_phase_t;

  typedef struct packed {
    logic [7:0]  char_in;
    logic [31:0] expected_line;
  } gclp_in_t;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            body_char;
    logic [2:0]            status;
    logic [31:0]           error_value;
    logic [7:0]            command_code_letter;
    logic [31:0]           code_number;
    logic [BODY_CNT_W-1:0] body_length;
    logic                  line_last;
  } gclp_out_t;

  typedef struct packed {
    gclp_phase_t           phase;
    logic                  digit_first;
    logic [31:0]           number_accum;
    logic [31:0]           code_accum;
    logic [7:0]            letter_seen;
    logic [7:0]            xor_running;
    logic [7:0]            check_accum;
    logic [BODY_CNT_W-1:0] body_count;
    logic [2:0]            status_held;
    logic [31:0]           error_held;
  } gclp_state_t;

  localparam gclp_state_t LINE_CLEAR = '{
    phase:        PH_START_N,
    digit_first:  1'b0,
    number_accum: 32'd0,
    code_accum:   32'd0,
    letter_seen:  8'd0,
    xor_running:  8'd0,
    check_accum:  8'd0,
    body_count:   '0,
    status_held:  ST_OK,
    error_held:   32'd0
  };

  function automatic logic lead_skip(input logic [7:0] b);
    return (b < CH_STAR) || b[7];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b - CH_CASE) : b;
  endfunction

  // acc * 10 + (b - '0'), wrapping
  function automatic logic [31:0] dec_step(input logic [31:0] acc, input logic [7:0] b);
    return (acc << 3) + (acc << 1) + {24'd0, b} - {24'd0, CH_ZERO};
  endfunction

endpackage

FILE: hdl/gclp_step.sv
`timescale 1ns / 1ps

module gclp_step (
  input  gclp_pkg::gclp_state_t state,
  input  gclp_pkg::gclp_in_t    item,
  input  logic [31:0]           agv_address,
  output gclp_pkg::gclp_state_t state_next,
  output logic                  emit,
  output gclp_pkg::gclp_out_t   result
);
  import gclp_pkg::*;

  gclp_state_t ns;
  logic        fin;
  logic        emit_body;
  logic        emit_sum;
  logic [2:0]  sum_status;
  logic [31:0] sum_error;
  logic [7:0]  b;
  logic [31:0] expv;

  assign b    = item.char_in;
  assign expv = item.expected_line;

  // Phases are visited in order so that a byte that closes one field falls
  // through to the next phase within the same cycle.
  always_comb begin
    ns         = state;
    fin        = 1'b0;
    emit_body  = 1'b0;
    emit_sum   = 1'b0;
    sum_status = state.status_held;
    sum_error  = state.error_held;

    if (b == CH_NUL) begin
      emit_sum = 1'b1;
      unique case (state.phase)
        PH_START_N, PH_START_A, PH_LETTER: begin
          sum_status = ST_LETTER;
          sum_error  = expv;
        end
        PH_NUM_N: begin
          if (expv != 32'd0 && state.number_accum != expv) begin
            sum_status = ST_LINE;
            sum_error  = state.number_accum;
          end else begin
            sum_status = ST_LETTER;
            sum_error  = expv;
          end
        end
        PH_NUM_A: begin
          if (state.number_accum != agv_address) begin
            sum_status = ST_ADDR;
            sum_error  = 32'd0;
          end else begin
            sum_status = ST_LETTER;
            sum_error  = expv;
          end
        end
        PH_CHECK: begin
          if (state.check_accum != state.xor_running) begin
            sum_status = ST_CHECKSUM;
            sum_error  = expv;
          end
        end
        default: begin
        end
      endcase
      ns = LINE_CLEAR;
    end else begin
      if (ns.phase == PH_START_N) begin
        if (lead_skip(b)) begin
          fin = 1'b1;
        end else if (to_upper(b) == CH_N) begin
          ns.xor_running  = ns.xor_running ^ b;
          ns.number_accum = 32'd0;
          ns.digit_first  = 1'b1;
          ns.phase        = PH_NUM_N;
          fin = 1'b1;
        end else begin
          ns.phase = PH_START_A;
        end
      end

      if (!fin && ns.phase == PH_NUM_N) begin
        if (ns.digit_first || is_digit(b)) begin
          ns.xor_running  = ns.xor_running ^ b;
          ns.number_accum = dec_step(ns.number_accum, b);
          ns.digit_first  = 1'b0;
          fin = 1'b1;
        end else if (expv != 32'd0 && ns.number_accum != expv) begin
          ns.status_held = ST_LINE;
          ns.error_held  = ns.number_accum;
          ns.phase       = PH_DONE;
          fin = 1'b1;
        end else begin
          ns.phase = PH_START_A;
        end
      end

      if (!fin && ns.phase == PH_START_A) begin
        if (lead_skip(b)) begin
          fin = 1'b1;
        end else if (to_upper(b) == CH_A) begin
          ns.xor_running  = ns.xor_running ^ b;
          ns.number_accum = 32'd0;
          ns.digit_first  = 1'b1;
          ns.phase        = PH_NUM_A;
          fin = 1'b1;
        end else begin
          ns.phase = PH_LETTER;
        end
      end

      if (!fin && ns.phase == PH_NUM_A) begin
        if (ns.digit_first || is_digit(b)) begin
          ns.xor_running  = ns.xor_running ^ b;
          ns.number_accum = dec_step(ns.number_accum, b);
          ns.digit_first  = 1'b0;
          fin = 1'b1;
        end else if (ns.number_accum != agv_address) begin
          ns.status_held = ST_ADDR;
          ns.error_held  = 32'd0;
          ns.phase       = PH_DONE;
          fin = 1'b1;
        end else begin
          ns.phase = PH_LETTER;
        end
      end

      if (!fin && ns.phase == PH_LETTER) begin
        fin = 1'b1;
        if (!lead_skip(b)) begin
          ns.xor_running = ns.xor_running ^ b;
          ns.letter_seen = b;
          if (b != CH_G && b != CH_M && b != CH_I) begin
            ns.status_held = ST_LETTER;
            ns.error_held  = expv;
            ns.phase       = PH_DONE;
          end else begin
            ns.code_accum  = 32'd0;
            ns.digit_first = 1'b1;
            ns.phase       = PH_CODE;
          end
        end
      end

      if (!fin && ns.phase == PH_CODE) begin
        if (ns.digit_first || is_digit(b)) begin
          ns.xor_running = ns.xor_running ^ b;
          ns.code_accum  = dec_step(ns.code_accum, b);
          ns.digit_first = 1'b0;
          fin = 1'b1;
        end else begin
          ns.phase = PH_PREBODY;
        end
      end

      if (!fin && ns.phase == PH_PREBODY) begin
        if (lead_skip(b)) begin
          fin = 1'b1;
        end else begin
          ns.phase = PH_BODY;
        end
      end

      if (!fin && ns.phase == PH_BODY) begin
        fin = 1'b1;
        if (ns.body_count >= BODY_CNT_W'(MAX_BODY)) begin
          // body full: only a checksum may follow
          if (b == CH_STAR) begin
            ns.check_accum = 8'd0;
            ns.digit_first = 1'b1;
            ns.phase       = PH_CHECK;
          end else begin
            ns.phase = PH_DONE;
          end
        end else if (b < CH_STAR) begin
          ns.phase = PH_BODY;
        end else if (b == CH_SEMI) begin
          ns.phase = PH_DONE;
        end else if (b == CH_STAR) begin
          ns.check_accum = 8'd0;
          ns.digit_first = 1'b1;
          ns.phase       = PH_CHECK;
        end else begin
          ns.xor_running = ns.xor_running ^ b;
          ns.body_count  = ns.body_count + BODY_CNT_W'(1);
          emit_body      = 1'b1;
        end
      end

      if (!fin && ns.phase == PH_CHECK) begin
        fin = 1'b1;
        if (ns.digit_first || is_digit(b)) begin
          ns.check_accum = 8'(dec_step({24'd0, ns.check_accum}, b));
          ns.digit_first = 1'b0;
        end else if (ns.check_accum != ns.xor_running) begin
          ns.status_held = ST_CHECKSUM;
          ns.error_held  = expv;
          ns.phase       = PH_DONE;
        end else begin
          ns.phase = PH_DONE;
        end
      end
    end
  end

  assign state_next = ns;
  assign emit       = emit_body || emit_sum;

  always_comb begin
    if (emit_sum) begin
      result.kind                = 1'b1;
      result.body_char           = 8'd0;
      result.status              = sum_status;
      result.error_value         = sum_error;
      result.command_code_letter = state.letter_seen;
      result.code_number         = state.code_accum;
      result.body_length         = state.body_count;
      result.line_last           = 1'b1;
    end else begin
      result.kind                = 1'b0;
      result.body_char           = to_upper(b);
      result.status              = ST_OK;
      result.error_value         = 32'd0;
      result.command_code_letter = ns.letter_seen;
      result.code_number         = ns.code_accum;
      result.body_length         = ns.body_count;
      result.line_last           = 1'b0;
    end
  end

endmodule

FILE: hdl/gclp_out_reg.sv
`timescale 1ns / 1ps

module gclp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  gclp_pkg::gclp_out_t load_data,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output gclp_pkg::gclp_out_t out_data
);
  import gclp_pkg::*;

  // A new result may replace the held one in the cycle it is taken.
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

FILE: hdl/gcode_line_parser_xor_check.sv
`timescale 1ns / 1ps

// G-code line parser with XOR checksum. Bytes of a line enter one per
// transaction on the input channel, ended by byte 0; each kept body byte
// leaves as an upper-cased character result, and the terminator leaves as a
// summary result with status, error value, command letter, code number and
// body length. One byte is taken per clock while the output side keeps
// taking results: the byte is held in an input register, and the parse
// state and the result register are updated from it when the result
// register has room. agv_address is written through cfg_we / cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
module gcode_line_parser_xor_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  gclp_pkg::gclp_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gclp_pkg::gclp_out_t out_data
);
  import gclp_pkg::*;

  logic        [31:0] agv_address;
  logic               stg_valid;
  gclp_in_t           stg_data;
  gclp_state_t        state;
  gclp_state_t        state_next;
  logic               emit;
  gclp_out_t          result;
  logic               room;
  logic               advance;

  assign advance  = stg_valid && room;
  assign in_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      agv_address <= 32'd0;
    end else if (cfg_we) begin
      agv_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_data <= in_data;
    end
  end

  // Advance the parse state only when the byte's result can be stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LINE_CLEAR;
    end else if (advance) begin
      state <= state_next;
    end
  end

  gclp_step u_step (
    .state       (state),
    .item        (stg_data),
    .agv_address (agv_address),
    .state_next  (state_next),
    .emit        (emit),
    .result      (result)
  );

  gclp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
